// ===== rtl/spcv_pkg.sv =====
// Shared types and constants for the packet chain validator.
// No dependencies; every other file imports this package.
package spcv_pkg;

  localparam int WinW    = 40;
  localparam int SizeW   = 56;
  localparam int KeyW    = 16;
  localparam int PktCntW = 17;
  localparam int VcntW   = 4;

  localparam logic [KeyW-1:0]  KeySh     = 16'h5348;
  localparam logic [KeyW-1:0]  KeySt     = 16'h5354;
  localparam logic [7:0]       Sv7Byte   = 8'h07;
  localparam logic [WinW-1:0]  MinWindow = 40'd16;
  localparam logic [WinW-1:0]  HdrBytes  = 40'd8;
  localparam logic [4:0]       FixedHdr  = 5'd6;
  localparam logic [WinW-1:0]  WindowRst = 40'd536870912;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_VARINT,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_UNDECIDED = 2'd0,
    ST_ACCEPT    = 2'd1,
    ST_REJECT    = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } item_t;

  typedef struct packed {
    phase_t              phase;
    logic [WinW-1:0]     byte_offset;
    logic [WinW-1:0]     packet_start;
    logic [SizeW-1:0]    size_acc;
    logic [VcntW-1:0]    varint_count;
    logic [KeyW-1:0]     packet_key;
    logic [PktCntW-1:0]  packet_count;
    status_t             decision;
    logic [WinW-1:0]     result_len;
    logic                magic_ok;
    logic [2:0]          hdr_idx;
  } state_t;

  localparam state_t StateReset = '{
    phase:        PH_IDLE,
    byte_offset:  '0,
    packet_start: '0,
    size_acc:     '0,
    varint_count: '0,
    packet_key:   '0,
    packet_count: '0,
    decision:     ST_UNDECIDED,
    result_len:   '0,
    magic_ok:     1'b1,
    hdr_idx:      '0
  };

  localparam state_t StateFirst = '{
    phase:        PH_HDR,
    byte_offset:  '0,
    packet_start: '0,
    size_acc:     '0,
    varint_count: '0,
    packet_key:   '0,
    packet_count: '0,
    decision:     ST_UNDECIDED,
    result_len:   '0,
    magic_ok:     1'b1,
    hdr_idx:      '0
  };

  // "MPCK" byte by header position
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h4D;
      2'd1:    b = 8'h50;
      2'd2:    b = 8'h43;
      default: b = 8'h4B;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/sv8_packet_chain_validator.sv =====
// Top level of the SV8 packet chain validator: config register, input stage, core, output valid.
// Depends on spcv_pkg, spcv_in_reg and spcv_core.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   in       | in_valid / in_ready    | in_data_byte[7:0], in_first
//   out      | out_valid / out_ready  | out_status[1:0], out_carved_length[39:0]
//   cfg      | cfg_wr_en (no wait)    | cfg_wr_data[39:0] (window length)
//
// One item per cycle sustained while the output is not stalled; each item is captured in the
// input register, and its result is registered in the state/result registers when the core takes it,
// since the whole byte step sits between the input register and the state/result registers.
// Reset (rst_n low, synchronous) clears the parser to idle and the window to 2^29.
// A stalled output holds the result and the input register; in_ready stays high
// while the input register is empty or draining.
module sv8_packet_chain_validator #(
  parameter int MAX_PACKETS      = 100000,
  parameter int MAX_VARINT_BYTES = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_first,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic [spcv_pkg::WinW-1:0] out_carved_length,
  input  logic                      cfg_wr_en,
  input  logic [spcv_pkg::WinW-1:0] cfg_wr_data
);
  import spcv_pkg::*;

  logic [WinW-1:0] window_r, window_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            item_valid, advance;
  item_t           item;
  status_t         status;

  assign window_nxt = cfg_wr_en ? cfg_wr_data : window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WindowRst;
    end else begin
      window_r <= window_nxt;
    end
  end

  // advance only when the result slot is free or being emptied
  assign advance       = item_valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  spcv_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_first     (in_first),
    .advance      (advance),
    .item_valid   (item_valid),
    .item         (item)
  );

  spcv_core #(
    .MAX_PACKETS      (MAX_PACKETS),
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .item          (item),
    .window        (window_r),
    .status        (status),
    .carved_length (out_carved_length)
  );

  assign out_valid  = out_valid_r;
  assign out_status = status;

endmodule

// ===== rtl/spcv_in_reg.sv =====
// Input register stage: captures one byte item and holds it until the core takes it.
// Depends on spcv_pkg for the item type.
module spcv_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_data_byte,
  input  logic            in_first,
  input  logic            advance,
  output logic            item_valid,
  output spcv_pkg::item_t item
);
  import spcv_pkg::*;

  logic  hold_valid_r, hold_valid_nxt;
  item_t item_r;

  assign in_ready       = !hold_valid_r || advance;
  assign hold_valid_nxt = (in_valid && in_ready) || (hold_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.data_byte <= in_data_byte;
      item_r.first     <= in_first;
    end
  end

  assign item_valid = hold_valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/spcv_core.sv =====
// Parser state and one-byte step logic; the decision registers double as the result register.
// Depends on spcv_pkg for state, phase and status types.
module spcv_core #(
  parameter int MAX_PACKETS      = 100000,
  parameter int MAX_VARINT_BYTES = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  spcv_pkg::item_t           item,
  input  logic [spcv_pkg::WinW-1:0] window,
  output spcv_pkg::status_t         status,
  output logic [spcv_pkg::WinW-1:0] carved_length
);
  import spcv_pkg::*;

  state_t st_r, st_nxt, eff;

  logic [WinW:0]      bo_inc;
  logic               past_win, next_past_win;
  logic [SizeW-1:0]   acc_new;
  logic [VcntW-1:0]   vcnt_new;
  logic [4:0]         hdr_plus_vint;
  logic               size_short, exact_fit;
  logic               start_past_win, size_over, no_next_hdr, skip_done;
  logic [WinW-1:0]    room, pkt_end, win_less8;
  logic [PktCntW-1:0] pcnt_inc;
  logic [KeyW-1:0]    key_new;
  logic               mok_new;
  logic [7:0]         b;

  // restart on a first byte before stepping
  always_comb begin
    eff = st_r;
    if (item.first) begin
      eff = StateFirst;
      if (window < MinWindow) begin
        eff.decision = ST_REJECT;
        eff.phase    = PH_DONE;
      end
    end
  end

  assign b              = item.data_byte;
  assign bo_inc         = {1'b0, eff.byte_offset} + {{WinW{1'b0}}, 1'b1};
  assign past_win       = eff.byte_offset >= window;
  assign next_past_win  = bo_inc >= {1'b0, window};
  assign acc_new        = {eff.size_acc[SizeW-8:0], b[6:0]};
  assign vcnt_new       = eff.varint_count + 4'd1;
  assign hdr_plus_vint  = FixedHdr + {1'b0, vcnt_new};
  assign size_short     = (acc_new[SizeW-1:4] == '0) && ({1'b0, acc_new[3:0]} < hdr_plus_vint);
  assign exact_fit      = (acc_new[SizeW-1:4] == '0) && ({1'b0, acc_new[3:0]} == hdr_plus_vint);
  assign start_past_win = eff.packet_start > window;
  assign room           = window - eff.packet_start;
  assign size_over      = (acc_new[SizeW-1:WinW] != '0) || (acc_new[WinW-1:0] > room);
  assign pkt_end        = eff.packet_start + acc_new[WinW-1:0];
  assign win_less8      = window - HdrBytes;
  assign no_next_hdr    = (window < HdrBytes) || (pkt_end > win_less8);
  assign skip_done      = bo_inc >= {1'b0, eff.packet_start};
  assign pcnt_inc       = eff.packet_count + {{(PktCntW-1){1'b0}}, 1'b1};
  assign key_new        = {eff.packet_key[7:0], b};
  assign mok_new        = eff.magic_ok && (b == magic_byte(eff.hdr_idx[1:0]));

  always_comb begin
    st_nxt = eff;
    if ((eff.phase inside {PH_HDR, PH_VARINT}) && past_win) begin
      st_nxt.decision = ST_REJECT;
      st_nxt.phase    = PH_DONE;
    end else begin
      case (eff.phase)
        PH_HDR: begin
          st_nxt.hdr_idx = eff.hdr_idx + 3'd1;
          if (eff.hdr_idx < 3'd4) begin
            st_nxt.magic_ok = mok_new;
            if (eff.hdr_idx == 3'd3 && !mok_new) begin
              // not SV8: only an SV7 signature at the very start passes
              if (eff.packet_start == '0 && b == Sv7Byte) begin
                st_nxt.decision = ST_ACCEPT;
              end else begin
                st_nxt.decision = ST_REJECT;
              end
              st_nxt.result_len = '0;
              st_nxt.phase      = PH_DONE;
            end
          end else begin
            st_nxt.packet_key = key_new;
            if (eff.hdr_idx >= 3'd5) begin
              if (eff.packet_start == '0 && key_new != KeySh) begin
                st_nxt.decision = ST_REJECT;
                st_nxt.phase    = PH_DONE;
              end else begin
                st_nxt.phase        = PH_VARINT;
                st_nxt.size_acc     = '0;
                st_nxt.varint_count = '0;
              end
            end
          end
        end
        PH_VARINT: begin
          st_nxt.size_acc     = acc_new;
          st_nxt.varint_count = vcnt_new;
          if (b[7]) begin
            if (vcnt_new >= VcntW'(MAX_VARINT_BYTES) || next_past_win) begin
              st_nxt.decision = ST_REJECT;
              st_nxt.phase    = PH_DONE;
            end
          end else if (size_short || start_past_win || size_over) begin
            st_nxt.decision = ST_REJECT;
            st_nxt.phase    = PH_DONE;
          end else if (eff.packet_key == KeySt) begin
            st_nxt.decision   = ST_ACCEPT;
            st_nxt.result_len = pkt_end;
            st_nxt.phase      = PH_DONE;
          end else begin
            st_nxt.packet_count = pcnt_inc;
            st_nxt.packet_start = pkt_end;
            if (pcnt_inc >= PktCntW'(MAX_PACKETS) || no_next_hdr) begin
              st_nxt.decision = ST_REJECT;
              st_nxt.phase    = PH_DONE;
            end else begin
              st_nxt.magic_ok   = 1'b1;
              st_nxt.packet_key = '0;
              st_nxt.hdr_idx    = '0;
              // next header starts right after this varint when there is no payload
              st_nxt.phase      = exact_fit ? PH_HDR : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (skip_done) begin
            st_nxt.phase   = PH_HDR;
            st_nxt.hdr_idx = '0;
          end
        end
        default: begin
        end
      endcase
    end
    if (eff.phase != PH_IDLE && eff.phase != PH_DONE) begin
      st_nxt.byte_offset = bo_inc[WinW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StateReset;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  assign status        = st_r.decision;
  assign carved_length = (st_r.decision == ST_ACCEPT) ? st_r.result_len : '0;

  a_decided_done : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.decision != ST_UNDECIDED) |-> (st_r.phase == PH_DONE))
    else $error("decision set outside the done phase");

  a_len_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.result_len != '0) |-> (st_r.decision == ST_ACCEPT))
    else $error("carved length set without accept");

  a_vcnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.varint_count <= VcntW'(MAX_VARINT_BYTES))
    else $error("varint byte count beyond limit");

  a_hold_state : assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(st_r))
    else $error("parser state moved without an item");

endmodule

// ===== sim/sv8_packet_chain_validator_test.sv =====
// Self-checking bench for sv8_packet_chain_validator: a directed table, then random
// packet chains under several idling patterns. Results are checked by a built-in parser model.
// Depends on spcv_pkg and the RTL under rtl/.
module sv8_packet_chain_validator_test;
  import spcv_pkg::*;

  localparam int PacketBudget  = 24;
  localparam int MaxVarint     = 8;
  localparam int TimeoutCycles = 200000;
  localparam logic [31:0] MagicWord = 32'h4D50434B;
  localparam logic [WinW-1:0] WindowMax = '1;

  typedef struct packed {
    status_t         st;
    logic [WinW-1:0] len;
  } verdict_t;

  typedef struct packed {
    logic [7:0] b;
    logic       f;
    logic       filler;
  } slot_t;

  typedef struct packed {
    logic            cfg;
    logic [WinW-1:0] win;
    logic [7:0]      b;
    logic            f;
    logic            typed;
    status_t         st;
    logic [WinW-1:0] len;
  } plan_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [7:0]      in_data_byte;
  logic            in_first;
  logic            out_valid;
  logic            out_ready;
  logic [1:0]      out_status;
  logic [WinW-1:0] out_carved_length;
  logic            cfg_wr_en;
  logic [WinW-1:0] cfg_wr_data;

  verdict_t verdicts_due[$];
  slot_t    byte_q[$];
  plan_t    plan[$];
  int       fail_count = 0;
  int       send_idle = 0;
  int       stall_pct = 0;

  // parser state mirrored from the block
  phase_t          ps_phase;
  logic [WinW-1:0] ps_offset;
  logic [WinW-1:0] ps_start;
  logic [SizeW-1:0] ps_size;
  logic [3:0]      ps_vcount;
  logic [KeyW-1:0] ps_key;
  logic [16:0]     ps_count;
  status_t         ps_decision;
  logic [WinW-1:0] ps_result_len;
  logic            ps_magic_ok;
  logic [WinW-1:0] win_len;

  sv8_packet_chain_validator #(
    .MAX_PACKETS(PacketBudget),
    .MAX_VARINT_BYTES(MaxVarint)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_first(in_first),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_carved_length(out_carved_length),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_parser(phase_t ph);
    ps_phase      = ph;
    ps_offset     = '0;
    ps_start      = '0;
    ps_size       = '0;
    ps_vcount     = '0;
    ps_key        = '0;
    ps_count      = '0;
    ps_decision   = ST_UNDECIDED;
    ps_result_len = '0;
    ps_magic_ok   = 1'b1;
  endfunction

  function automatic void settle(status_t d, logic [63:0] len);
    ps_decision   = d;
    ps_result_len = (d == ST_ACCEPT) ? len[WinW-1:0] : '0;
    ps_phase      = PH_DONE;
  endfunction

  function automatic void close_size_field();
    logic [63:0] sz, start, win, next_start;
    sz    = {8'd0, ps_size};
    start = {24'd0, ps_start};
    win   = {24'd0, win_len};
    if (sz < 64'(FixedHdr) + 64'(ps_vcount)) begin
      settle(ST_REJECT, '0);
      return;
    end
    if (start > win || sz > win - start) begin
      settle(ST_REJECT, '0);
      return;
    end
    if (ps_key == KeySt) begin
      settle(ST_ACCEPT, start + sz);
      return;
    end
    ps_count = ps_count + 17'd1;
    if (ps_count >= PacketBudget) begin
      settle(ST_REJECT, '0);
      return;
    end
    next_start = start + sz;
    ps_start   = next_start[WinW-1:0];
    // next header must fit whole inside the window
    if (win < 64'(HdrBytes) || {24'd0, ps_start} > win - 64'(HdrBytes)) begin
      settle(ST_REJECT, '0);
      return;
    end
    ps_magic_ok = 1'b1;
    ps_key      = '0;
    ps_phase    = ({24'd0, ps_start} == {24'd0, ps_offset} + 64'd1) ? PH_HDR : PH_SKIP;
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    logic [63:0] rel, offs;
    logic [31:0] mword;
    offs = {24'd0, ps_offset};
    if ((ps_phase == PH_HDR || ps_phase == PH_VARINT) && offs >= {24'd0, win_len}) begin
      settle(ST_REJECT, '0);
      return;
    end
    case (ps_phase)
      PH_HDR: begin
        rel = offs - {24'd0, ps_start};
        if (rel < 64'd4) begin
          mword = MagicWord >> (8 * (3 - int'(rel)));
          if (b != mword[7:0]) ps_magic_ok = 1'b0;
          if (rel == 64'd3 && !ps_magic_ok) begin
            // not MPCK: only an SV7 start survives
            if (ps_start == '0 && b == Sv7Byte) settle(ST_ACCEPT, '0);
            else settle(ST_REJECT, '0);
          end
        end else begin
          ps_key = {ps_key[7:0], b};
          if (rel >= 64'd5) begin
            if (ps_start == '0 && ps_key != KeySh) begin
              settle(ST_REJECT, '0);
            end else begin
              ps_phase  = PH_VARINT;
              ps_size   = '0;
              ps_vcount = '0;
            end
          end
        end
      end
      PH_VARINT: begin
        ps_size   = {ps_size[SizeW-8:0], b[6:0]};
        ps_vcount = ps_vcount + 4'd1;
        if (b[7]) begin
          if (ps_vcount >= MaxVarint || offs + 64'd1 >= {24'd0, win_len}) settle(ST_REJECT, '0);
        end else begin
          close_size_field();
        end
      end
      PH_SKIP: begin
        if (offs + 64'd1 >= {24'd0, ps_start}) ps_phase = PH_HDR;
      end
      default: ;
    endcase
  endfunction

  function automatic verdict_t predict_verdict(logic [7:0] b, logic f);
    verdict_t v;
    if (f) begin
      clear_parser(PH_HDR);
      if (win_len < MinWindow) settle(ST_REJECT, '0);
    end
    if (ps_phase != PH_IDLE && ps_phase != PH_DONE) begin
      scan_byte(b);
      ps_offset = ps_offset + 40'd1;
    end
    v.st  = ps_decision;
    v.len = (ps_decision == ST_ACCEPT) ? ps_result_len : '0;
    return v;
  endfunction

  function automatic void plan_row(logic cfg, logic [WinW-1:0] win, logic [7:0] b, logic f,
                                   logic typed, status_t st, logic [WinW-1:0] len);
    plan_t r;
    r = {cfg, win, b, f, typed, st, len};
    plan.insert(plan.size(), r);
  endfunction

  function automatic void push_slot(logic [7:0] b, logic f, logic filler);
    slot_t s;
    s = {b, f, filler};
    byte_q.insert(byte_q.size(), s);
  endfunction

  function automatic logic [WinW-1:0] pick_window();
    logic [WinW-1:0] w;
    case ($urandom_range(0, 9))
      0:       w = WindowRst;
      1:       w = WindowMax;
      2:       w = '0;
      3:       w = MinWindow - 40'd1;
      4:       w = MinWindow;
      8:       w = 40'($urandom_range(400, 4000));
      9:       w = {8'($urandom), 32'($urandom)};
      default: w = 40'($urandom_range(16, 400));
    endcase
    return w;
  endfunction

  // Append one candidate: a packet chain, mostly well formed, or a few noise bytes.
  task automatic queue_stream();
    int npk, pay, vlen, shape, first_idx, idx;
    logic [SizeW-1:0] sz, t;
    logic [KeyW-1:0] key;
    logic [31:0] mword;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) push_slot(8'($urandom), $urandom_range(0, 7) == 0, 1'b1);
      return;
    end
    npk = ($urandom_range(0, 11) == 0) ? $urandom_range(PacketBudget - 1, PacketBudget + 1)
                                      : $urandom_range(1, 4);
    first_idx = byte_q.size();
    for (int p = 0; p < npk; p++) begin
      if (p == 0) key = ($urandom_range(0, 9) == 0) ? 16'($urandom) : KeySh;
      else if (p == npk - 1 && $urandom_range(0, 3) != 0) key = KeySt;
      else key = 16'($urandom);
      if (npk > 4) pay = $urandom_range(0, 2);
      else pay = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
      for (int i = 0; i < 4; i++) begin
        mword = MagicWord >> (8 * (3 - i));
        push_slot(mword[7:0], p == 0 && i == 0, 1'b0);
      end
      push_slot(key[15:8], 1'b0, 1'b0);
      push_slot(key[7:0], 1'b0, 1'b0);
      vlen = 1;
      while (6 + vlen + pay >= (1 << (7 * vlen))) vlen++;
      shape = $urandom_range(0, 19);
      if (shape < 3) vlen += $urandom_range(1, 3);  // padded with leading zero groups
      sz = 56'(6 + vlen + pay);
      if (shape == 3) begin
        sz  = 56'($urandom_range(0, 5 + vlen));
        pay = 0;
      end else if (shape == 4) begin
        sz   = 56'({$urandom, $urandom});
        vlen = MaxVarint;
        pay  = 0;
      end else if (shape == 5) begin
        vlen = MaxVarint + 1;
        pay  = 0;
      end
      for (int i = vlen - 1; i >= 0; i--) begin
        t = sz >> (7 * i);
        push_slot({i != 0, t[6:0]}, 1'b0, 1'b0);
      end
      repeat (pay) push_slot(8'($urandom), 1'b0, 1'b0);
      if (shape >= 3 && shape <= 5) break;
    end
    if ($urandom_range(0, 5) == 0) begin
      idx = $urandom_range(first_idx + 1, byte_q.size() - 1);
      byte_q[idx].b = 8'($urandom);
    end
  endtask

  task automatic send_item(logic [7:0] b, logic f, logic typed, status_t st,
                           logic [WinW-1:0] len);
    verdict_t v;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_first     <= f;
    do @(posedge clk); while (!in_ready);
    v = predict_verdict(b, f);
    if (typed) begin
      v.st  = st;
      v.len = len;
    end
    verdicts_due.insert(verdicts_due.size(), v);
  endtask

  // Drain every outstanding result, then write the window.
  task automatic write_window(logic [WinW-1:0] w);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_len = w;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : check_results
    verdict_t v;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected item: status %0d, carved_length %0d", out_status, out_carved_length);
        fail_count++;
      end else begin
        v = verdicts_due.pop_front();
        if (out_status !== v.st) begin
          $error("status: expected %0d, got %0d", v.st, out_status);
          fail_count++;
        end
        if (out_carved_length !== v.len) begin
          $error("carved_length: expected %0d, got %0d", v.len, out_carved_length);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(TimeoutCycles * 12);
    $display("FAIL");
    $finish;
  end

  initial begin
    slot_t s;
    int counted;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    in_first     <= 1'b0;
    out_ready    <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    clear_parser(PH_IDLE);
    win_len = WindowRst;

    // bytes before any start are ignored
    plan_row(0, '0, 8'hFF, 0, 1, ST_UNDECIDED, '0);
    // windows too small for any chain
    plan_row(1, MinWindow - 40'd1, 8'h4D, 1, 1, ST_REJECT, '0);
    plan_row(1, '0, 8'hFF, 1, 1, ST_REJECT, '0);
    // SV7 start, then the decision repeats
    plan_row(1, WindowMax, 8'h00, 1, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'hFF, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h80, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h07, 0, 1, ST_ACCEPT, '0);
    plan_row(0, '0, 8'h55, 0, 1, ST_ACCEPT, '0);
    // bad magic on the last byte
    plan_row(0, '0, 8'h4D, 1, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h50, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h43, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h4A, 0, 1, ST_REJECT, '0);
    // SH then ST, both of size 7, in the smallest allowed window
    plan_row(1, MinWindow, 8'h4D, 1, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h50, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h43, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h4B, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h53, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h48, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h07, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h4D, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h50, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h43, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h4B, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h53, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h54, 0, 0, ST_UNDECIDED, '0);
    plan_row(0, '0, 8'h07, 0, 1, ST_ACCEPT, 40'd14);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].cfg) write_window(plan[i].win);
      send_item(plan[i].b, plan[i].f, plan[i].typed, plan[i].st, plan[i].len);
    end

    // a chain cut at a phase boundary resumes under the new window
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 72; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 72; end
        default: begin send_idle = 21; stall_pct = 21; end
      endcase
      write_window((p == 0) ? WindowRst : pick_window());
      counted = 0;
      while (counted < 100) begin
        if (byte_q.size() == 0) queue_stream();
        s = byte_q.pop_front();
        send_item(s.b, s.f, 1'b0, ST_UNDECIDED, '0);
        if (!s.filler) counted++;
      end
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/spcv_pkg.sv
rtl/spcv_in_reg.sv
rtl/spcv_core.sv
rtl/sv8_packet_chain_validator.sv
sim/sv8_packet_chain_validator_test.sv
